// File: rtl/sqvg_pkg.sv
// ---------------------------------------------------------------------------
// sqvg_pkg
// Types and constants shared by the sprite quad vertex generator modules.
// ---------------------------------------------------------------------------
package sqvg_pkg;

    // One sprite as it enters the block.
    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] size_w;
        logic signed [15:0] size_h;
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_y;
        logic [15:0]        angle;
        logic [63:0]        src_rect;
        logic [31:0]        tex_size;
        logic [31:0]        tint;
        logic [17:0]        group_key;
        logic [1:0]         batch_position;
    } sprite_t;

    // One vertex as it leaves the block.
    typedef struct packed {
        logic signed [15:0] vertex_x;
        logic signed [15:0] vertex_y;
        logic [16:0]        tex_u;
        logic [16:0]        tex_v;
        logic [31:0]        color;
        logic [15:0]        vertex_number;
        logic               group_break;
        logic               batch_done;
        logic               last;
    } vertex_t;

    // Per-sprite setup handed from the front to the back.
    typedef struct packed {
        logic signed [16:0] cx;
        logic signed [16:0] cy;
        logic signed [16:0] dx0;
        logic signed [16:0] dx1;
        logic signed [16:0] dy0;
        logic signed [16:0] dy1;
        logic signed [15:0] sin_q14;
        logic signed [15:0] cos_q14;
        logic [16:0]        u0;
        logic [16:0]        u1;
        logic [16:0]        v0;
        logic [16:0]        v1;
        logic [31:0]        color;
        logic [15:0]        base_count;
        logic               brk;
        logic               last_sprite;
    } job_t;

    typedef enum logic [3:0] {
        F_IDLE,
        F_IDX,
        F_RECIP,
        F_QN,
        F_PHASE,
        F_SQ,
        F_POLY1,
        F_POLY2,
        F_POLY3,
        F_PUSH
    } front_state_t;

    // Quarter-wave sine polynomial coefficients, Q14.
    localparam logic [14:0] POLY_A = 15'd25736;
    localparam logic [14:0] POLY_B = 15'd10512;
    localparam logic [14:0] POLY_C = 15'd1160;
    localparam logic [14:0] Q14_ONE = 15'd16384;

    localparam int JOB_QUEUE_DEPTH = 2;
    localparam int OUT_QUEUE_DEPTH = 4;
    localparam int OUT_CNT_W = 3;

endpackage

// File: rtl/sprite_quad_vertex_generator.sv
// ---------------------------------------------------------------------------
// sprite_quad_vertex_generator
// Expands sorted sprites into four textured, rotated corner vertices.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel: drive one sprite on 'sprite' with push high; it is taken
//   at a clock edge where full is low. Output channel: while empty is low the
//   oldest vertex sits on 'vertex'; raise pop to take it. Each sprite yields
//   four vertices in corner order top-left, top-right, bottom-right,
//   bottom-left; the fourth carries last.
// Sequencing: full stays high from the edge that takes a sprite until the front
//   has pushed its setup into the job queue, so a new sprite is taken only after
//   the setup of the last one has left. The front sequencer does the setup: it
//   quantizes the angle with a reciprocal multiply, then runs the sine and
//   cosine polynomial in two lanes, one multiply a step, while four texture
//   divide lanes produce four quotient bits a step.
//   The back then issues one corner per cycle while a setup waits and the vertex queue has room.
// A zero angle yields sine 0 and cosine exactly one, so the corners are the
//   plain translated offsets with no rounding error.
// Reset: clears the group key and vertex count to zero and empties both
//   queues; no clearing pass.
// Stall: when pop stays low the vertex queue fills, the back holds its
//   current sprite, the job queue fills and full stays high.
// ---------------------------------------------------------------------------
module sprite_quad_vertex_generator #(
    parameter int SINE_TABLE_ENTRIES = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  sqvg_pkg::sprite_t sprite,
    output logic              full,
    input  logic              pop,
    output sqvg_pkg::vertex_t vertex,
    output logic              empty
);
    import sqvg_pkg::*;

    localparam int JOB_CNT_W = $clog2(JOB_QUEUE_DEPTH) + 1;

    // Front to job queue
    logic    job_push;
    job_t    job_in;
    logic    job_full;

    // Job queue to back
    logic    job_pop;
    job_t    job_out;
    logic    job_empty;
    logic [JOB_CNT_W-1:0] job_count;

    // Back to vertex queue
    logic    out_push;
    vertex_t out_item;
    logic    out_full;
    logic [OUT_CNT_W-1:0] out_count;

    // Accept and set up sprites
    sqvg_front #(
        .SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .sprite   (sprite),
        .full     (full),
        .job_push (job_push),
        .job      (job_in),
        .job_full (job_full)
    );

    // Decouple setup from corner expansion
    sqvg_fifo #(
        .DEPTH  (JOB_QUEUE_DEPTH),
        .item_t (job_t)
    ) u_job_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .din   (job_in),
        .full  (job_full),
        .pop   (job_pop),
        .dout  (job_out),
        .empty (job_empty),
        .count (job_count)
    );

    // Expand each setup into four corners
    sqvg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (job_empty || (job_count == '0)),
        .job       (job_out),
        .job_pop   (job_pop),
        .out_count (out_count),
        .out_push  (out_push),
        .out_item  (out_item)
    );

    // Hold finished vertices until the receiver pops them; the back never
    // pushes without room, so out_full only mirrors the count
    sqvg_fifo #(
        .DEPTH  (OUT_QUEUE_DEPTH),
        .item_t (vertex_t)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push && !out_full),
        .din   (out_item),
        .full  (out_full),
        .pop   (pop),
        .dout  (vertex),
        .empty (empty),
        .count (out_count)
    );

endmodule

// File: rtl/sqvg_fifo.sv
// ---------------------------------------------------------------------------
// sqvg_fifo
// Small register queue with occupancy count; DEPTH is a power of two.
// ---------------------------------------------------------------------------
module sqvg_fifo #(
    parameter int DEPTH = 2,
    parameter type item_t = logic
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  item_t                  din,
    output logic                   full,
    input  logic                   pop,
    output item_t                  dout,
    output logic                   empty,
    output logic [$clog2(DEPTH):0] count
);
    localparam int AW = $clog2(DEPTH);

    item_t          mem_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg;
    logic [AW-1:0]  rd_ptr_reg;
    logic [AW:0]    cnt_reg;
    logic [AW:0]    cnt_next;
    logic           do_push;
    logic           do_pop;

    assign full    = (cnt_reg == (AW+1)'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign count   = cnt_reg;
    assign dout    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// File: rtl/sqvg_front.sv
// ---------------------------------------------------------------------------
// sqvg_front
// Accepts sprites, tracks the group key and count, and computes sine,
// cosine and texture coordinates over a short fixed step sequence.
// ---------------------------------------------------------------------------
module sqvg_front #(
    parameter int SINE_TABLE_ENTRIES = 1024
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  sqvg_pkg::sprite_t sprite,
    output logic             full,
    output logic             job_push,
    output sqvg_pkg::job_t   job,
    input  logic             job_full
);
    import sqvg_pkg::*;

    localparam int IDX_W   = $clog2(SINE_TABLE_ENTRIES);
    localparam int RECIP_W = 41 - IDX_W;
    localparam int RP_W    = RECIP_W + IDX_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << 40) / SINE_TABLE_ENTRIES);

    front_state_t state_reg;
    front_state_t state_next;
    logic         accept;

    sprite_t      spr_reg;
    logic [17:0]  group_reg;
    logic [15:0]  count_reg;
    logic [15:0]  base_reg;
    logic         brk_reg;

    logic [IDX_W-1:0] idx_reg;
    logic [15:0]      q0_reg;
    logic [31:0]      qn_reg;
    logic [14:0]      x_reg   [2];
    logic             neg_reg [2];
    logic [14:0]      x2_reg  [2];
    logic [14:0]      t_reg   [2];
    logic signed [15:0] sc_reg [2];

    logic [15:0] rem_reg  [4];
    logic [15:0] quo_reg  [4];
    logic [15:0] den_reg  [4];
    logic        sat_reg  [4];
    logic        zero_reg [4];
    logic [15:0] rem_step [4];
    logic [15:0] quo_step [4];
    logic [16:0] coord    [4];

    logic        first_spr;
    logic        brk_now;
    logic [15:0] base_now;
    logic [15:0] num_in [4];
    logic [15:0] den_in [4];

    logic [31:0]      ang_prod;
    logic [RP_W-1:0]  recip_prod;
    logic [31:0]      qn_prod;
    logic [31:0]      diff;
    logic [15:0]      phase;
    logic [15:0]      lane_ph [2];

    // Output and next-state logic
    always_comb
    begin
        full     = (state_reg != F_IDLE);
        accept   = push && !full;
        job_push = (state_reg == F_PUSH) && !job_full;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:  if (accept) state_next = F_IDX;
            F_IDX:   state_next = F_RECIP;
            F_RECIP: state_next = F_QN;
            F_QN:    state_next = F_PHASE;
            F_PHASE: state_next = F_SQ;
            F_SQ:    state_next = F_POLY1;
            F_POLY1: state_next = F_POLY2;
            F_POLY2: state_next = F_POLY3;
            F_POLY3: state_next = F_PUSH;
            F_PUSH:  if (!job_full) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    // Group tracking
    always_comb
    begin
        first_spr = sprite.batch_position[0];
        brk_now   = !first_spr && (sprite.group_key != group_reg);
        base_now  = (first_spr || brk_now) ? 16'd0 : count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            group_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                group_reg <= sprite.group_key;
                count_reg <= sprite.batch_position[1] ? 16'd0 : base_now + 16'd4;
            end
        end
    end

    // Texture divide lanes: u0, v0, u1, v1; four quotient bits a step
    always_comb
    begin
        num_in[0] = sprite.src_rect[63:48];
        num_in[1] = sprite.src_rect[47:32];
        num_in[2] = sprite.src_rect[31:16];
        num_in[3] = sprite.src_rect[15:0];
        den_in[0] = sprite.tex_size[31:16];
        den_in[1] = sprite.tex_size[15:0];
        den_in[2] = sprite.tex_size[31:16];
        den_in[3] = sprite.tex_size[15:0];
    end

    always_comb
    begin
        logic [15:0] rem_t;
        logic [15:0] quo_t;
        logic [16:0] wide;
        for (int l = 0; l < 4; l++)
        begin
            rem_t = rem_reg[l];
            quo_t = quo_reg[l];
            for (int b = 0; b < 4; b++)
            begin
                wide = {rem_t, 1'b0};
                if (wide >= {1'b0, den_reg[l]})
                begin
                    wide  = wide - {1'b0, den_reg[l]};
                    quo_t = {quo_t[14:0], 1'b1};
                end
                else
                begin
                    quo_t = {quo_t[14:0], 1'b0};
                end
                rem_t = wide[15:0];
            end
            rem_step[l] = rem_t;
            quo_step[l] = quo_t;
            if (sat_reg[l])
            begin
                coord[l] = 17'h10000;
            end
            else if (zero_reg[l])
            begin
                coord[l] = '0;
            end
            else
            begin
                coord[l] = {1'b0, quo_reg[l]};
            end
        end
    end

    // Angle quantization and phase of both lanes (sine, cosine)
    always_comb
    begin
        ang_prod   = 32'(spr_reg.angle) * 32'(SINE_TABLE_ENTRIES);
        recip_prod = RP_W'(idx_reg) * RP_W'(RECIP);
        qn_prod    = 32'(q0_reg) * 32'(SINE_TABLE_ENTRIES);
        diff       = (32'(idx_reg) << 16) - qn_reg;
        phase      = (diff >= 32'(SINE_TABLE_ENTRIES)) ? q0_reg + 16'd1 : q0_reg;
        lane_ph[0] = phase;
        lane_ph[1] = phase + 16'd16384;
    end

    always_ff @(posedge clk)
    begin
        logic [29:0] prod;
        logic [15:0] m;
        if (accept)
        begin
            spr_reg  <= sprite;
            base_reg <= base_now;
            brk_reg  <= brk_now;
            for (int l = 0; l < 4; l++)
            begin
                rem_reg[l]  <= num_in[l];
                quo_reg[l]  <= '0;
                den_reg[l]  <= den_in[l];
                sat_reg[l]  <= (den_in[l] == 16'd0) ? (num_in[l] != 16'd0)
                                                    : (num_in[l] >= den_in[l]);
                zero_reg[l] <= (den_in[l] == 16'd0) && (num_in[l] == 16'd0);
            end
        end
        if ((state_reg == F_IDX) || (state_reg == F_RECIP) ||
            (state_reg == F_QN) || (state_reg == F_PHASE))
        begin
            for (int l = 0; l < 4; l++)
            begin
                rem_reg[l] <= rem_step[l];
                quo_reg[l] <= quo_step[l];
            end
        end
        unique case (state_reg)
            F_IDX:   idx_reg <= ang_prod[16 +: IDX_W];
            F_RECIP: q0_reg  <= recip_prod[24 +: 16];
            F_QN:    qn_reg  <= qn_prod;
            F_PHASE:
            begin
                for (int s = 0; s < 2; s++)
                begin
                    x_reg[s]   <= lane_ph[s][14] ? Q14_ONE - {1'b0, lane_ph[s][13:0]}
                                                 : {1'b0, lane_ph[s][13:0]};
                    neg_reg[s] <= lane_ph[s][15];
                end
            end
            F_SQ:
            begin
                for (int s = 0; s < 2; s++)
                begin
                    prod      = 30'(x_reg[s]) * 30'(x_reg[s]);
                    x2_reg[s] <= prod[28:14];
                end
            end
            F_POLY1:
            begin
                for (int s = 0; s < 2; s++)
                begin
                    prod     = 30'(POLY_C) * 30'(x2_reg[s]);
                    t_reg[s] <= POLY_B - prod[28:14];
                end
            end
            F_POLY2:
            begin
                for (int s = 0; s < 2; s++)
                begin
                    prod     = 30'(t_reg[s]) * 30'(x2_reg[s]);
                    t_reg[s] <= POLY_A - prod[28:14];
                end
            end
            F_POLY3:
            begin
                for (int s = 0; s < 2; s++)
                begin
                    prod = 30'(t_reg[s]) * 30'(x_reg[s]);
                    m    = prod[29:14];
                    if (m > 16'd16384)
                    begin
                        m = 16'd16384;
                    end
                    sc_reg[s] <= neg_reg[s] ? -$signed(m) : $signed(m);
                end
            end
            default:
            begin
            end
        endcase
    end

    // Job assembly
    always_comb
    begin
        job.cx          = 17'(spr_reg.pos_x) + 17'(spr_reg.origin_x);
        job.cy          = 17'(spr_reg.pos_y) + 17'(spr_reg.origin_y);
        job.dx0         = -17'(spr_reg.origin_x);
        job.dx1         = 17'(spr_reg.size_w) - 17'(spr_reg.origin_x);
        job.dy0         = -17'(spr_reg.origin_y);
        job.dy1         = 17'(spr_reg.size_h) - 17'(spr_reg.origin_y);
        job.sin_q14     = sc_reg[0];
        job.cos_q14     = sc_reg[1];
        job.u0          = coord[0];
        job.v0          = coord[1];
        job.u1          = coord[2];
        job.v1          = coord[3];
        job.color       = spr_reg.tint;
        job.base_count  = base_reg;
        job.brk         = brk_reg;
        job.last_sprite = spr_reg.batch_position[1];
    end

endmodule

// File: rtl/sqvg_back.sv
// ---------------------------------------------------------------------------
// sqvg_back
// Expands one sprite setup into four corners: a product stage, then a
// rounding, translation and saturation stage into the vertex queue.
// ---------------------------------------------------------------------------
module sqvg_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         job_empty,
    input  sqvg_pkg::job_t               job,
    output logic                         job_pop,
    input  logic [sqvg_pkg::OUT_CNT_W-1:0] out_count,
    output logic                         out_push,
    output sqvg_pkg::vertex_t            out_item
);
    import sqvg_pkg::*;

    logic        issue;
    logic [1:0]  k_reg;
    logic        a_valid_reg;

    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic signed [32:0] pxc_reg;
    logic signed [32:0] pys_reg;
    logic signed [32:0] pxs_reg;
    logic signed [32:0] pyc_reg;
    logic signed [16:0] cx_reg;
    logic signed [16:0] cy_reg;
    vertex_t            meta_reg;

    logic signed [34:0] sum_x;
    logic signed [34:0] sum_y;
    logic signed [20:0] vx;
    logic signed [20:0] vy;

    function automatic logic signed [15:0] sat16(input logic signed [20:0] v);
        if (v > 21'sd32767)
        begin
            return 16'sh7FFF;
        end
        else if (v < -21'sd32768)
        begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    // Issue a corner only when the vertex queue has room for it
    assign issue   = !job_empty &&
                     (({1'b0, out_count} + (OUT_CNT_W+1)'(a_valid_reg)) <
                      (OUT_CNT_W+1)'(OUT_QUEUE_DEPTH));
    assign job_pop = issue && (k_reg == 2'd3);

    always_comb
    begin
        dx = ((k_reg == 2'd0) || (k_reg == 2'd3)) ? job.dx0 : job.dx1;
        dy = (k_reg < 2'd2) ? job.dy0 : job.dy1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg       <= '0;
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= issue;
            if (issue)
            begin
                k_reg <= k_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            pxc_reg <= dx * job.cos_q14;
            pys_reg <= dy * job.sin_q14;
            pxs_reg <= dx * job.sin_q14;
            pyc_reg <= dy * job.cos_q14;
            cx_reg  <= job.cx;
            cy_reg  <= job.cy;
            meta_reg.vertex_x      <= '0;
            meta_reg.vertex_y      <= '0;
            meta_reg.tex_u         <= ((k_reg == 2'd1) || (k_reg == 2'd2)) ? job.u1 : job.u0;
            meta_reg.tex_v         <= (k_reg >= 2'd2) ? job.v1 : job.v0;
            meta_reg.color         <= job.color;
            meta_reg.vertex_number <= job.base_count + 16'(k_reg);
            meta_reg.group_break   <= (k_reg == 2'd0) && job.brk;
            meta_reg.batch_done    <= (k_reg == 2'd3) && job.last_sprite;
            meta_reg.last          <= (k_reg == 2'd3);
        end
    end

    // Round half up by 14 bits (arithmetic shift floors), translate, saturate
    always_comb
    begin
        sum_x    = 35'(pxc_reg) - 35'(pys_reg) + 35'sd8192;
        sum_y    = 35'(pxs_reg) + 35'(pyc_reg) + 35'sd8192;
        vx       = 21'(sum_x >>> 14) + 21'(cx_reg);
        vy       = 21'(sum_y >>> 14) + 21'(cy_reg);
        out_item = meta_reg;
        out_item.vertex_x = sat16(vx);
        out_item.vertex_y = sat16(vy);
        out_push = a_valid_reg;
    end

endmodule

// File: rtl/sqvg_checker.sv
// ---------------------------------------------------------------------------
// sqvg_checker
// Port-level checks of the vertex generator, bound to the top level.
// ---------------------------------------------------------------------------
module sqvg_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              push,
    input sqvg_pkg::sprite_t sprite,
    input logic              full,
    input logic              pop,
    input sqvg_pkg::vertex_t vertex,
    input logic              empty
);
    import sqvg_pkg::*;

    // Hold a waiting vertex until it is popped
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(vertex)))
        else $error("waiting vertex changed before pop");

    // Block the input right after a sprite is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full) |=> full)
        else $error("second sprite taken during setup");

    // Fourth corner always lands on a count of three modulo four
    a_last_number: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && vertex.last) |-> (vertex.vertex_number[1:0] == 2'd3))
        else $error("last vertex misnumbered");

    // Break only on a fresh group's first corner
    a_break_first: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && vertex.group_break) |->
            (vertex.vertex_number == 16'd0 && !vertex.last))
        else $error("group break on wrong vertex");

    // Batch end only on a fourth corner
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && vertex.batch_done) |-> vertex.last)
        else $error("batch done without last");

endmodule

bind sprite_quad_vertex_generator sqvg_checker u_sqvg_checker (.*);
